/* rtl/srs_pkg.sv */
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the systematic resampler.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int MAX_PARTICLES        = 1024;
    localparam int WEIGHT_FRACTION_BITS = 24;

    localparam int IDX_W    = $clog2(MAX_PARTICLES);
    localparam int CNT_W    = IDX_W + 1;
    localparam int WEIGHT_W = WEIGHT_FRACTION_BITS + 1;
    localparam int OFFSET_W = WEIGHT_FRACTION_BITS;
    localparam int STEP_W   = WEIGHT_W;
    localparam int CUM_W    = 35;
    localparam int PC_W     = 11;
    localparam int OUT_IDX_W = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 2'd1;

    localparam logic [PC_W-1:0]   PARTICLE_COUNT_RESET = 11'd500;
    localparam logic [STEP_W-1:0] STEP_SIZE_RESET      = 25'd33554;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_DRAW,
        OP_NOT_READY
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic                first;
        logic                last;
        logic [IDX_W-1:0]    addr;
        logic [WEIGHT_W-1:0] data;
    } op_entry_t;

    typedef struct packed {
        logic [IDX_W-1:0]  count_m1;
        logic [STEP_W-1:0] step;
    } srs_cfg_t;

    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } back_state_t;

endpackage

/* rtl/srs_ram.sv */
// ----------------------------------------------------------------------------
// srs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module srs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/srs_front.sv */
// ----------------------------------------------------------------------------
// srs_front
// Configuration registers, command intake and round bookkeeping; turns each
// accepted draw and in-count load into a queued operation for the back end.
// ----------------------------------------------------------------------------
module srs_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             full,
    input  logic                             cmd,
    input  logic [srs_pkg::WEIGHT_W-1:0]     weight,
    input  logic [srs_pkg::OFFSET_W-1:0]     start_offset,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             push,
    output srs_pkg::op_entry_t               push_entry,
    output srs_pkg::srs_cfg_t                cfg
);

    logic [srs_pkg::PC_W-1:0]   particle_count_reg;
    logic [srs_pkg::STEP_W-1:0] step_size_reg;
    logic [srs_pkg::CNT_W-1:0]  loaded_reg, loaded_next;
    logic [srs_pkg::CNT_W-1:0]  drawn_reg, drawn_next;
    logic [srs_pkg::CNT_W-1:0]  n_eff;
    logic [srs_pkg::CNT_W-1:0]  drawn_inc;
    logic                       accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            particle_count_reg <= srs_pkg::PARTICLE_COUNT_RESET;
            step_size_reg      <= srs_pkg::STEP_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                srs_pkg::REG_PARTICLE_COUNT:
                begin
                    particle_count_reg <= cfg_data[srs_pkg::PC_W-1:0];
                end
                srs_pkg::REG_STEP_SIZE:
                begin
                    step_size_reg <= cfg_data[srs_pkg::STEP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (particle_count_reg == '0)
        begin
            n_eff = srs_pkg::CNT_W'(1);
        end
        else if (32'(particle_count_reg) > 32'(srs_pkg::MAX_PARTICLES))
        begin
            n_eff = srs_pkg::CNT_W'(srs_pkg::MAX_PARTICLES);
        end
        else
        begin
            n_eff = srs_pkg::CNT_W'(particle_count_reg);
        end
    end

    assign cfg.count_m1 = srs_pkg::IDX_W'(n_eff - 1'b1);
    assign cfg.step     = step_size_reg;

    assign accept    = start && !full;
    assign drawn_inc = drawn_reg + 1'b1;

    always_comb
    begin
        push             = 1'b0;
        push_entry.kind  = srs_pkg::OP_LOAD;
        push_entry.first = 1'b0;
        push_entry.last  = 1'b0;
        push_entry.addr  = loaded_reg[srs_pkg::IDX_W-1:0];
        push_entry.data  = weight;
        loaded_next      = loaded_reg;
        drawn_next       = drawn_reg;
        if (accept)
        begin
            if (cmd == srs_pkg::CMD_LOAD)
            begin
                if (loaded_reg < n_eff)
                begin
                    push             = 1'b1;
                    push_entry.first = (loaded_reg == '0);
                    loaded_next      = loaded_reg + 1'b1;
                end
            end
            else if (loaded_reg < n_eff)
            begin
                push            = 1'b1;
                push_entry.kind = srs_pkg::OP_NOT_READY;
            end
            else
            begin
                push             = 1'b1;
                push_entry.kind  = srs_pkg::OP_DRAW;
                push_entry.first = (drawn_reg == '0);
                push_entry.last  = (drawn_inc >= n_eff);
                push_entry.data  = srs_pkg::WEIGHT_W'(start_offset);
                if (drawn_inc >= n_eff)
                begin
                    loaded_next = '0;
                    drawn_next  = '0;
                end
                else
                begin
                    drawn_next = drawn_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
            drawn_reg  <= '0;
        end
        else
        begin
            loaded_reg <= loaded_next;
            drawn_reg  <= drawn_next;
        end
    end

endmodule

/* rtl/srs_queue.sv */
// ----------------------------------------------------------------------------
// srs_queue
// Short operation queue between the front end and the back end.
// ----------------------------------------------------------------------------
module srs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  srs_pkg::op_entry_t push_entry,
    input  logic               pop,
    output srs_pkg::op_entry_t head,
    output logic               full,
    output logic               empty
);

    srs_pkg::op_entry_t             entry_reg [srs_pkg::QUEUE_DEPTH];
    logic [srs_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [srs_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [srs_pkg::QCNT_W-1:0]     count_reg;

    assign full  = (count_reg == srs_pkg::QCNT_W'(srs_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("transfer pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

endmodule

/* rtl/srs_back.sv */
// ----------------------------------------------------------------------------
// srs_back
// Executes queued operations: cumulative-sum writes for loads, the pointer
// walk over the cumulative store for draws, or a not-ready result if unloaded.
// ----------------------------------------------------------------------------
module srs_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  srs_pkg::op_entry_t                head,
    input  logic                              empty,
    input  srs_pkg::srs_cfg_t                 cfg,
    output logic                              pop,
    output logic                              done,
    output logic [srs_pkg::OUT_IDX_W-1:0]     source_index,
    output logic                              last_draw,
    output logic                              status
);

    srs_pkg::back_state_t          state_reg, state_next;
    logic [srs_pkg::IDX_W-1:0]     wp_reg, wp_next;
    logic [srs_pkg::CUM_W-1:0]     pos_reg, pos_next;
    logic [srs_pkg::CUM_W-1:0]     sum_reg, sum_next;
    logic                          final_reg, final_next;
    logic                          done_reg, done_next;
    logic [srs_pkg::OUT_IDX_W-1:0] index_reg, index_next;
    logic                          last_draw_reg, last_draw_next;
    logic                          status_reg, status_next;

    logic                          we;
    logic [srs_pkg::CUM_W-1:0]     load_sum;
    logic [srs_pkg::CUM_W-1:0]     pos_step;
    logic [srs_pkg::CUM_W-1:0]     rdata;

    assign load_sum = (head.first ? '0 : sum_reg) + srs_pkg::CUM_W'(head.data);
    assign pos_step = pos_reg + srs_pkg::CUM_W'(cfg.step);

    srs_ram #(
        .WIDTH(srs_pkg::CUM_W),
        .DEPTH(srs_pkg::MAX_PARTICLES)
    ) u_cum_ram (
        .clk  (clk),
        .we   (we),
        .waddr(head.addr),
        .wdata(load_sum),
        .raddr(wp_next),
        .rdata(rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        final_next     = final_reg;
        done_next      = 1'b0;
        index_next     = index_reg;
        last_draw_next = last_draw_reg;
        status_next    = status_reg;
        pop            = 1'b0;
        we             = 1'b0;
        unique case (state_reg)
            srs_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        srs_pkg::OP_LOAD:
                        begin
                            we       = 1'b1;
                            sum_next = load_sum;
                        end
                        srs_pkg::OP_NOT_READY:
                        begin
                            done_next      = 1'b1;
                            index_next     = '0;
                            last_draw_next = 1'b0;
                            status_next    = srs_pkg::STATUS_NOT_READY;
                        end
                        srs_pkg::OP_DRAW:
                        begin
                            if (head.first)
                            begin
                                wp_next  = '0;
                                pos_next = srs_pkg::CUM_W'(head.data);
                            end
                            else
                            begin
                                pos_next = pos_step;
                            end
                            final_next = head.last;
                            state_next = srs_pkg::BK_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            srs_pkg::BK_WALK:
            begin
                if (wp_reg < cfg.count_m1 && rdata < pos_reg)
                begin
                    wp_next = wp_reg + 1'b1;
                end
                else
                begin
                    done_next      = 1'b1;
                    index_next     = srs_pkg::OUT_IDX_W'(wp_reg);
                    last_draw_next = final_reg;
                    status_next    = srs_pkg::STATUS_OK;
                    state_next     = srs_pkg::BK_IDLE;
                    if (final_reg)
                    begin
                        wp_next  = '0;
                        pos_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = srs_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srs_pkg::BK_IDLE;
            wp_reg    <= '0;
            pos_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            pos_reg   <= pos_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        final_reg     <= final_next;
        index_reg     <= index_next;
        last_draw_reg <= last_draw_next;
        status_reg    <= status_next;
    end

    assign done         = done_reg;
    assign source_index = index_reg;
    assign last_draw    = last_draw_reg;
    assign status       = status_reg;

    a_round_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && last_draw_reg) |-> (wp_reg == '0 && pos_reg == '0))
        else $error("walk state not cleared at round end");

    a_walk_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srs_pkg::BK_WALK && $past(state_reg) == srs_pkg::BK_WALK)
        |-> wp_reg == srs_pkg::IDX_W'($past(wp_reg) + 1'b1))
        else $error("walk stayed without advancing the pointer");

endmodule

/* rtl/systematic_resampler_core.sv */
// ----------------------------------------------------------------------------
// systematic_resampler_core
// Systematic resampling engine: loads cumulative weights, then returns one
// resampled source index per draw command.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  command  | start / busy         | cmd, weight, start_offset
//  result   | done (1-cycle)       | source_index, last_draw, status
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A load is one cumulative-store write in the back end; a draw walks the
//  pointer, one cumulative-store read per cycle. Over a round the pointer moves
//  at most n_eff-1 steps, n_eff being particle_count clamped to 1..1024.
//  busy is high while the two-entry command queue is full.
//  Reset clears counts, pointer and queue; the cumulative store is not
//  cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module systematic_resampler_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             cmd,
    input  logic [srs_pkg::WEIGHT_W-1:0]     weight,
    input  logic [srs_pkg::OFFSET_W-1:0]     start_offset,
    output logic                             done,
    output logic [srs_pkg::OUT_IDX_W-1:0]    source_index,
    output logic                             last_draw,
    output logic                             status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    srs_pkg::op_entry_t push_entry;
    srs_pkg::op_entry_t head;
    srs_pkg::srs_cfg_t  cfg;

    assign busy = full;

    srs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .full        (full),
        .cmd         (cmd),
        .weight      (weight),
        .start_offset(start_offset),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .push_entry  (push_entry),
        .cfg         (cfg)
    );

    srs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    srs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .cfg         (cfg),
        .pop         (pop),
        .done        (done),
        .source_index(source_index),
        .last_draw   (last_draw),
        .status      (status)
    );

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for systematic_resampler_core. An in-order predictor
// tracks the cumulative weights, counts, walk pointer and draw position and
// builds the expected index for every draw. Directed rounds cover the edge
// cases, then random rounds of normalized weights run with noise mixed in.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [srs_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam int unsigned ONE_Q        = 1 << srs_pkg::WEIGHT_FRACTION_BITS;
    localparam int unsigned OFFSET_MAX   = (1 << srs_pkg::OFFSET_W) - 1;
    localparam int unsigned WEIGHT_MAX   = (1 << srs_pkg::WEIGHT_W) - 1;
    localparam int          RANDOM_ITEMS = 590;

    typedef struct packed {
        logic [srs_pkg::OUT_IDX_W-1:0] source_index;
        logic                          last_draw;
        logic                          status;
    } pick_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           cmd;
    logic [srs_pkg::WEIGHT_W-1:0]   weight;
    logic [srs_pkg::OFFSET_W-1:0]   start_offset;
    logic                           done;
    logic [srs_pkg::OUT_IDX_W-1:0]  source_index;
    logic                           last_draw;
    logic                           status;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [srs_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [srs_pkg::CUM_W-1:0]  cum_sum [srs_pkg::MAX_PARTICLES];
    logic [srs_pkg::PC_W-1:0]   pc_reg;
    logic [srs_pkg::STEP_W-1:0] step_reg;
    int unsigned                n_loaded;
    int unsigned                n_drawn;
    int unsigned                walk_idx;
    logic [srs_pkg::CUM_W-1:0]  draw_pos;

    pick_t pending_picks[$];
    pick_t front_pick;
    int    err_count;
    int    item_count;
    bit    start_drv;
    bit    no_gaps;

    systematic_resampler_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .weight       (weight),
        .start_offset (start_offset),
        .done         (done),
        .source_index (source_index),
        .last_draw    (last_draw),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("ERROR at %0t: %s got %0h, want %0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic predict_pick(input logic c, input logic [srs_pkg::WEIGHT_W-1:0] w,
                                input logic [srs_pkg::OFFSET_W-1:0] off);
        int unsigned n;
        pick_t       p;
        n = 32'(pc_reg);
        if (n == 0)
            n = 1;
        if (n > srs_pkg::MAX_PARTICLES)
            n = srs_pkg::MAX_PARTICLES;
        if (c == srs_pkg::CMD_LOAD)
        begin
            if (n_loaded < n)
            begin
                if (n_loaded == 0)
                    cum_sum[n_loaded] = srs_pkg::CUM_W'(w);
                else
                    cum_sum[n_loaded] = cum_sum[n_loaded - 1] + srs_pkg::CUM_W'(w);
                n_loaded++;
            end
            return;
        end
        if (n_loaded < n)
        begin
            p.source_index = '0;
            p.last_draw    = 1'b0;
            p.status       = srs_pkg::STATUS_NOT_READY;
        end
        else
        begin
            if (n_drawn == 0)
            begin
                draw_pos = srs_pkg::CUM_W'(off);
                walk_idx = 0;
            end
            else
                draw_pos = draw_pos + srs_pkg::CUM_W'(step_reg);
            while (walk_idx + 1 < n && cum_sum[walk_idx] < draw_pos)
                walk_idx++;
            p.source_index = srs_pkg::OUT_IDX_W'(walk_idx);
            p.status       = srs_pkg::STATUS_OK;
            n_drawn++;
            p.last_draw = (n_drawn >= n);
            if (p.last_draw)
            begin
                n_loaded = 0;
                n_drawn  = 0;
                walk_idx = 0;
                draw_pos = '0;
            end
        end
        pending_picks = {pending_picks, p};
    endtask

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // call at a rising edge; returns at a rising edge
    task automatic send_item(input logic c, input int unsigned w,
                             input int unsigned off);
        bit taken;
        int gap;
        start        <= 1'b1;
        start_drv    = 1'b1;
        cmd          <= c;
        weight       <= srs_pkg::WEIGHT_W'(w);
        start_offset <= srs_pkg::OFFSET_W'(off);
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        predict_pick(c, srs_pkg::WEIGHT_W'(w), srs_pkg::OFFSET_W'(off));
        item_count++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start     <= 1'b0;
            start_drv = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        if (start_drv)
        begin
            start     <= 1'b0;
            start_drv = 1'b0;
        end
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [srs_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned data);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= srs_pkg::CFG_DATA_W'(data);
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        if (idx == srs_pkg::REG_PARTICLE_COUNT)
            pc_reg = srs_pkg::PC_W'(data);
        else if (idx == srs_pkg::REG_STEP_SIZE)
            step_reg = srs_pkg::STEP_W'(data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_picks.size() == 0)
                flag_mismatch("result with none pending, source_index",
                              32'(source_index), 32'(0));
            else
            begin
                front_pick = pending_picks.pop_front();
                if (source_index !== front_pick.source_index)
                    flag_mismatch("source_index", 32'(source_index),
                                  32'(front_pick.source_index));
                if (last_draw !== front_pick.last_draw)
                    flag_mismatch("last_draw", 32'(last_draw), 32'(front_pick.last_draw));
                if (status !== front_pick.status)
                    flag_mismatch("status", 32'(status), 32'(front_pick.status));
            end
        end
    end

    // draws before the round is loaded, count register zero, step zero
    task automatic test_single_particle();
        send_item(srs_pkg::CMD_DRAW, 0, OFFSET_MAX);
        send_item(srs_pkg::CMD_LOAD, WEIGHT_MAX, 0);
        send_item(srs_pkg::CMD_DRAW, 0, 0);
        wait_idle();
        write_reg(srs_pkg::REG_PARTICLE_COUNT, 0);
        write_reg(srs_pkg::REG_STEP_SIZE, 0);
        write_reg(REG_UNMAPPED, WEIGHT_MAX);
        send_item(srs_pkg::CMD_DRAW, 0, OFFSET_MAX);
        send_item(srs_pkg::CMD_LOAD, ONE_Q, 0);
        send_item(srs_pkg::CMD_LOAD, ONE_Q - 1, 0);
        send_item(srs_pkg::CMD_DRAW, 0, 0);
    endtask

    // early draw, full-scale weight, load past the count
    task automatic test_small_round();
        wait_idle();
        write_reg(srs_pkg::REG_PARTICLE_COUNT, 3);
        write_reg(srs_pkg::REG_STEP_SIZE, ONE_Q / 3);
        send_item(srs_pkg::CMD_LOAD, 0, 0);
        send_item(srs_pkg::CMD_LOAD, ONE_Q, 0);
        send_item(srs_pkg::CMD_DRAW, 0, 0);
        send_item(srs_pkg::CMD_LOAD, 0, 0);
        send_item(srs_pkg::CMD_LOAD, ONE_Q - 1, 0);
        repeat (3) send_item(srs_pkg::CMD_DRAW, 0, 0);
    endtask

    task automatic test_offset_above_step();
        wait_idle();
        write_reg(srs_pkg::REG_PARTICLE_COUNT, 2);
        write_reg(srs_pkg::REG_STEP_SIZE, 1000);
        repeat (2) send_item(srs_pkg::CMD_LOAD, ONE_Q / 2, 0);
        repeat (2) send_item(srs_pkg::CMD_DRAW, 0, OFFSET_MAX);
    endtask

    task automatic test_mid_round_count();
        wait_idle();
        write_reg(srs_pkg::REG_PARTICLE_COUNT, 4);
        write_reg(srs_pkg::REG_STEP_SIZE, ONE_Q / 4);
        repeat (4) send_item(srs_pkg::CMD_LOAD, 1, 0);
        repeat (2) send_item(srs_pkg::CMD_DRAW, 0, 100);
        wait_idle();
        write_reg(srs_pkg::REG_PARTICLE_COUNT, 2);
        send_item(srs_pkg::CMD_DRAW, 0, 0);
        wait_idle();
        write_reg(srs_pkg::REG_PARTICLE_COUNT, 6);
        repeat (2) send_item(srs_pkg::CMD_LOAD, ONE_Q / 8, 0);
        wait_idle();
        write_reg(srs_pkg::REG_PARTICLE_COUNT, 1);
        send_item(srs_pkg::CMD_LOAD, ONE_Q / 8, 0);
        send_item(srs_pkg::CMD_DRAW, 0, 5);
    endtask

    // count register above the maximum, largest step, walk to the last index
    task automatic test_full_size_round();
        wait_idle();
        write_reg(srs_pkg::REG_PARTICLE_COUNT, (1 << srs_pkg::PC_W) - 1);
        write_reg(srs_pkg::REG_STEP_SIZE, WEIGHT_MAX);
        repeat (srs_pkg::MAX_PARTICLES - 1)
            send_item(srs_pkg::CMD_LOAD, $urandom_range(0, 16383), 0);
        send_item(srs_pkg::CMD_DRAW, 0, 0);
        send_item(srs_pkg::CMD_LOAD, $urandom_range(0, 16383), 0);
        repeat (2) send_item(srs_pkg::CMD_DRAW, 0, $urandom_range(0, OFFSET_MAX));
        wait_idle();
        write_reg(srs_pkg::REG_PARTICLE_COUNT, 1);
        send_item(srs_pkg::CMD_DRAW, 0, 0);
    endtask

    task automatic test_random_rounds();
        int          base;
        int          r;
        int unsigned n;
        int unsigned pc;
        int unsigned stp;
        int unsigned remaining;
        int unsigned w;
        int unsigned hi;
        int unsigned draws;
        bit          noisy;
        base = item_count;
        while (item_count - base < RANDOM_ITEMS)
        begin
            wait_idle();
            r = $urandom_range(0, 99);
            if (r < 80)
                n = $urandom_range(1, 12);
            else if (r < 95)
                n = $urandom_range(13, 64);
            else
                n = $urandom_range(65, 200);
            pc  = (n == 1 && $urandom_range(0, 1)) ? 0 : n;
            stp = ($urandom_range(0, 9) < 8) ? ONE_Q / n : $urandom_range(0, WEIGHT_MAX);
            if ($urandom_range(0, 1))
            begin
                write_reg(srs_pkg::REG_PARTICLE_COUNT, pc);
                write_reg(srs_pkg::REG_STEP_SIZE, stp);
            end
            else
            begin
                write_reg(srs_pkg::REG_STEP_SIZE, stp);
                write_reg(srs_pkg::REG_PARTICLE_COUNT, pc);
            end
            repeat ($urandom_range(1, 4))
            begin
                no_gaps   = ($urandom_range(0, 3) == 0);
                noisy     = ($urandom_range(0, 4) == 0);
                remaining = ONE_Q;
                for (int unsigned i = 0; i < n; i++)
                begin
                    if (i == n - 1)
                        w = remaining;
                    else
                    begin
                        w = $urandom_range(0, 2 * remaining / (n - i));
                        if (w > remaining)
                            w = remaining;
                    end
                    remaining -= w;
                    if (noisy && $urandom_range(0, 3) == 0)
                        w = $urandom_range(0, WEIGHT_MAX);
                    send_item(srs_pkg::CMD_LOAD, w, $urandom_range(0, OFFSET_MAX));
                    if (noisy && $urandom_range(0, 9) == 0)
                        send_item(srs_pkg::CMD_DRAW, $urandom_range(0, WEIGHT_MAX),
                                  $urandom_range(0, OFFSET_MAX));
                end
                if (noisy && $urandom_range(0, 1))
                    send_item(srs_pkg::CMD_LOAD, $urandom_range(0, WEIGHT_MAX), 0);
                hi = (stp == 0) ? 0 : stp - 1;
                if (hi > OFFSET_MAX || noisy)
                    hi = OFFSET_MAX;
                draws = (noisy && $urandom_range(0, 2) == 0) ? $urandom_range(0, n) : n;
                for (int unsigned d = 0; d < draws; d++)
                    send_item(srs_pkg::CMD_DRAW, $urandom_range(0, WEIGHT_MAX),
                              (d == 0) ? $urandom_range(0, hi) : $urandom_range(0, OFFSET_MAX));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        cmd          <= srs_pkg::CMD_LOAD;
        weight       <= '0;
        start_offset <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= srs_pkg::REG_PARTICLE_COUNT;
        cfg_data     <= '0;
        pc_reg     = srs_pkg::PARTICLE_COUNT_RESET;
        step_reg   = srs_pkg::STEP_SIZE_RESET;
        n_loaded   = 0;
        n_drawn    = 0;
        walk_idx   = 0;
        draw_pos   = '0;
        err_count  = 0;
        item_count = 0;
        start_drv  = 1'b0;
        no_gaps    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_particle();
        test_small_round();
        test_offset_above_step();
        test_mid_round_count();
        test_full_size_round();
        test_random_rounds();

        wait_idle();
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
rtl/srs_pkg.sv
rtl/srs_ram.sv
rtl/srs_front.sv
rtl/srs_queue.sv
rtl/srs_back.sv
rtl/systematic_resampler_core.sv
tb/sv/tb.sv
